### rtl/tvf_pkg.sv
// ----------------------------------------------------------------------------
// tvf_pkg
// Type codes and shared types for the typed value to float32 converter.
// ----------------------------------------------------------------------------
package tvf_pkg;

  typedef enum logic [3:0] {
    TC_U8  = 4'd0,
    TC_S8  = 4'd1,
    TC_U16 = 4'd2,
    TC_S16 = 4'd3,
    TC_U32 = 4'd4,
    TC_S32 = 4'd5,
    TC_U64 = 4'd6,
    TC_S64 = 4'd7,
    TC_F32 = 4'd8,
    TC_F64 = 4'd9
  } type_code_t;

  localparam logic [31:0] F32_INF  = 32'h7F80_0000;
  localparam logic [31:0] F32_QNAN = 32'h7FC0_0000;

  // Stage 1 output: a magnitude and its scale, or a finished word.
  typedef struct packed {
    logic              is_final;   // final_bits holds the result
    logic [31:0]       final_bits;
    logic              sign;
    logic [63:0]       mag;        // nonzero when is_final is low
    logic signed [12:0] exp;       // value = mag * 2^exp
  } norm_req_t;

endpackage

### rtl/typed_value_to_float32.sv
// ----------------------------------------------------------------------------
// typed_value_to_float32
// Converts a typed integer or float value to IEEE-754 single precision.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_ready) carries type_code, value_bytes and
// byte_count; output channel (out_valid/out_ready) carries float_bits.
// The converter is a four-stage pipeline: decode, leading-one search,
// normalize shift, then round and pack. An accepted beat passes through the
// stages in that order before it appears on the output, and one beat can be
// accepted every cycle while the receiver does not stall the output.
// The pipeline advances as a whole whenever the last stage is empty or its
// beat is taken, so in_ready follows that condition.
// When the receiver stalls on a waiting output beat, every stage holds its
// beat and in_ready drops at once, even if earlier stages hold bubbles;
// nothing is lost or repeated.
// Reset clears all stage valid bits; payload registers are not reset.
// ----------------------------------------------------------------------------
module typed_value_to_float32 (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [3:0]  type_code,
  input  logic [63:0] value_bytes,
  input  logic [7:0]  byte_count,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] float_bits
);

  logic advance;
  tvf_pkg::norm_req_t dec, s1, s2, s3;
  logic v1, v2, v3, v4;
  logic [5:0] lz2, msb2;
  logic [5:0] lz_next;
  logic [63:0] norm3;
  logic signed [13:0] ex3;
  logic [31:0] res_next;

  assign advance  = !v4 || out_ready;
  assign in_ready = advance;

  tvf_decode u_dec (
    .type_code  (type_code),
    .value_bytes(value_bytes),
    .byte_count (byte_count),
    .req        (dec)
  );

  always_comb begin
    lz_next = 6'd63;
    for (int i = 0; i < 64; i++) begin
      if (s1.mag[i]) lz_next = 6'(63 - i);
    end
  end

  // Fields for rounding on normalized mantissa in stage 4.
  logic [6:0]  rshift;
  logic [63:0] mant;
  logic [24:0] keep;
  logic        rbit, sticky;
  logic [31:0] packed_bits;

  always_comb begin
    // norm3 has its leading one at bit 63; value = norm3 * 2^(ex3-63).
    if (ex3 >= -14'sd126) rshift = 7'd0;
    else if (ex3 < -14'sd200) rshift = 7'd64;
    else rshift = 7'(-14'sd126 - ex3);
    mant = (rshift >= 7'd64) ? 64'd0 : (norm3 >> rshift);
    sticky = (rshift >= 7'd64) ? 1'b1 : (|(norm3 & ~(mant << rshift)));
    // Keep 24 bits of mant[63:40], round bit 39, sticky below.
    keep = {1'b0, mant[63:40]};
    rbit = mant[39];
    sticky = sticky | (|mant[38:0]);
    if (rbit && (sticky || keep[0])) keep = keep + 25'd1;
    if (ex3 > 14'sd127) begin
      packed_bits = tvf_pkg::F32_INF;
    end else begin
      packed_bits = (ex3 >= -14'sd126) ? {1'b0, 8'(ex3 + 14'sd126), 23'd0} : 32'd0;
      packed_bits = packed_bits + {7'd0, keep};
      if (packed_bits >= tvf_pkg::F32_INF) packed_bits = tvf_pkg::F32_INF;
    end
    res_next = s3.is_final ? s3.final_bits : {s3.sign, packed_bits[30:0]};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0; v2 <= 1'b0; v3 <= 1'b0; v4 <= 1'b0;
    end else if (advance) begin
      v1 <= in_valid; v2 <= v1; v3 <= v2; v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s1 <= dec;
      s2 <= s1;
      lz2 <= lz_next;
      msb2 <= 6'd63 - lz_next;
      s3 <= s2;
      norm3 <= s2.mag << lz2;
      ex3 <= 14'(s2.exp) + $signed({8'd0, msb2});
      float_bits <= res_next;
    end
  end

  assign out_valid = v4;

endmodule

### rtl/tvf_decode.sv
// ----------------------------------------------------------------------------
// tvf_decode
// Selects the source field by type, takes the magnitude of signed integers and
// unpacks float64 fields into a magnitude and exponent, or a finished word.
// ----------------------------------------------------------------------------
module tvf_decode (
  input  logic [3:0]        type_code,
  input  logic [63:0]       value_bytes,
  input  logic [7:0]        byte_count,
  output tvf_pkg::norm_req_t req
);

  logic [63:0] raw;
  logic        is_signed;
  logic        valid_len;
  logic [63:0] neg;
  logic [10:0] dexp;
  logic [51:0] dfrac;

  assign dexp  = value_bytes[62:52];
  assign dfrac = value_bytes[51:0];

  always_comb begin
    raw       = 64'd0;
    is_signed = 1'b0;
    valid_len = 1'b0;
    neg       = 64'd0;
    req       = '0;
    case (type_code)
      tvf_pkg::TC_U8:  begin raw = {56'd0, value_bytes[63:56]}; valid_len = 1'b1; end
      tvf_pkg::TC_S8:  begin
        raw = {{56{value_bytes[63]}}, value_bytes[63:56]}; is_signed = 1'b1; valid_len = 1'b1;
      end
      tvf_pkg::TC_U16: begin raw = {48'd0, value_bytes[63:48]}; valid_len = byte_count >= 8'd2; end
      tvf_pkg::TC_S16: begin
        raw = {{48{value_bytes[63]}}, value_bytes[63:48]}; is_signed = 1'b1;
        valid_len = byte_count >= 8'd2;
      end
      tvf_pkg::TC_U32: begin raw = {32'd0, value_bytes[63:32]}; valid_len = byte_count >= 8'd4; end
      tvf_pkg::TC_S32: begin
        raw = {{32{value_bytes[63]}}, value_bytes[63:32]}; is_signed = 1'b1;
        valid_len = byte_count >= 8'd4;
      end
      tvf_pkg::TC_U64: begin raw = value_bytes; valid_len = byte_count >= 8'd8; end
      tvf_pkg::TC_S64: begin raw = value_bytes; is_signed = 1'b1; valid_len = byte_count >= 8'd8; end
      tvf_pkg::TC_F32: valid_len = byte_count >= 8'd4;
      tvf_pkg::TC_F64: valid_len = byte_count >= 8'd8;
      default: valid_len = 1'b0;
    endcase

    neg = ~raw + 64'd1;
    req.is_final = 1'b1;
    if (byte_count == 8'd0 || !valid_len) begin
      req.final_bits = 32'd0;
    end else if (type_code == tvf_pkg::TC_F32) begin
      req.final_bits = value_bytes[63:32];
    end else if (type_code == tvf_pkg::TC_F64) begin
      req.sign = value_bytes[63];
      if (dexp == 11'h7FF) begin
        req.final_bits = (dfrac == 52'd0) ? {value_bytes[63], tvf_pkg::F32_INF[30:0]}
                       : {value_bytes[63], tvf_pkg::F32_QNAN[30:0] | {8'd0, dfrac[51:29]}};
      end else if (dexp == 11'd0 && dfrac == 52'd0) begin
        req.final_bits = {value_bytes[63], 31'd0};
      end else begin
        req.is_final = 1'b0;
        if (dexp == 11'd0) begin
          req.mag = {12'd0, dfrac};
          req.exp = -13'sd1074;
        end else begin
          req.mag = {11'd0, 1'b1, dfrac};
          req.exp = $signed({2'b00, dexp}) - 13'sd1075;
        end
      end
    end else if (raw == 64'd0) begin
      req.final_bits = 32'd0;
    end else begin
      req.is_final = 1'b0;
      req.sign     = is_signed & raw[63];
      req.mag      = (is_signed & raw[63]) ? neg : raw;
      req.exp      = 13'sd0;
    end
  end

endmodule

### rtl/tvf_checker.sv
// ----------------------------------------------------------------------------
// tvf_checker
// Port-level checks for the typed value to float32 converter.
// ----------------------------------------------------------------------------
module tvf_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] float_bits
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(float_bits))
    else $error("output beat changed while stalled");

  a_ready_free: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output");

  a_latency: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready ##1 out_ready ##1 out_ready ##1 out_ready |=> out_valid)
    else $error("beat did not emerge after four cycles");

  a_reset: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid after reset");

endmodule

bind typed_value_to_float32 tvf_checker u_tvf_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .float_bits(float_bits)
);

### dv/tb_typed_value_to_float32.sv
// ----------------------------------------------------------------------------
// tb_typed_value_to_float32
// Self-checking testbench for the typed value to float32 converter. Directed
// beats cover every type code, field extremes and the float special cases.
// Random beats follow, with idle bursts on both channels. A scoreboard
// predicts each float word and compares it with the output in order.
// ----------------------------------------------------------------------------
module tb_typed_value_to_float32;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [3:0] TC_OTHER_LO = 4'd10;
  localparam logic [3:0] TC_OTHER_HI = 4'd15;
  localparam int N_RANDOM = 1700;

  class float_scoreboard;
    logic [31:0] pending_words[$];
    int          errors;

    function new();
      errors = 0;
    endfunction

    static function int top_bit(logic [63:0] m);
      int p;
      p = 0;
      for (int i = 63; i >= 0; i--) begin
        if (m[i]) begin
          p = i;
          break;
        end
      end
      return p;
    endfunction

    // Rounds sign * m * 2^e to single precision, nearest even; m nonzero.
    static function logic [31:0] round_pack(logic [31:0] sgn, logic [63:0] m, int e);
      int ex, lsb_exp, shift;
      logic [63:0] keep, rem, half;
      logic [31:0] bits;
      ex = top_bit(m) + e;
      if (ex > 127) return sgn | tvf_pkg::F32_INF;
      lsb_exp = (ex >= -126) ? ex - 23 : -149;
      shift = lsb_exp - e;
      if (shift <= 0) begin
        keep = m << (-shift);
      end else if (shift > 64) begin
        keep = 64'd0;
      end else begin
        if (shift == 64) begin
          keep = 64'd0;
          rem  = m;
          half = 64'h8000_0000_0000_0000;
        end else begin
          keep = m >> shift;
          rem  = m & ((64'd1 << shift) - 64'd1);
          half = 64'd1 << (shift - 1);
        end
        if (rem > half || (rem == half && keep[0])) keep = keep + 64'd1;
      end
      bits = (ex >= -126) ? (32'(ex + 126) << 23) : 32'd0;
      bits = bits + keep[31:0];
      if (bits >= tvf_pkg::F32_INF) bits = tvf_pkg::F32_INF;
      return sgn | bits;
    endfunction

    static function logic [31:0] from_uint(logic [63:0] v);
      if (v == 64'd0) return 32'd0;
      return round_pack(32'd0, v, 0);
    endfunction

    static function logic [31:0] from_sint(logic [63:0] v, int w);
      logic [63:0] mask;
      mask = (w >= 64) ? '1 : ((64'd1 << w) - 64'd1);
      v = v & mask;
      if (!v[w-1]) return from_uint(v);
      return round_pack(32'h8000_0000, ((~v) + 64'd1) & mask, 0);
    endfunction

    static function logic [31:0] from_double(logic [63:0] d);
      logic [31:0] sgn;
      logic [10:0] ex;
      logic [63:0] frac;
      sgn  = {d[63], 31'd0};
      ex   = d[62:52];
      frac = {12'd0, d[51:0]};
      if (ex == 11'h7FF) begin
        if (frac == 64'd0) return sgn | tvf_pkg::F32_INF;
        // NaN keeps the top fraction bits and is forced quiet.
        return sgn | tvf_pkg::F32_QNAN | 32'(frac >> 29);
      end
      if (ex == 11'd0) begin
        if (frac == 64'd0) return sgn;
        return round_pack(sgn, frac, -1074);
      end
      return round_pack(sgn, frac | (64'd1 << 52), int'(ex) - 1075);
    endfunction

    static function logic [31:0] convert(logic [3:0] tc, logic [63:0] vb, logic [7:0] bc);
      logic [31:0] r;
      r = 32'd0;
      if (bc != 8'd0) begin
        case (tc)
          tvf_pkg::TC_U8:  r = from_uint(vb >> 56);
          tvf_pkg::TC_S8:  r = from_sint(vb >> 56, 8);
          tvf_pkg::TC_U16: if (bc >= 8'd2) r = from_uint(vb >> 48);
          tvf_pkg::TC_S16: if (bc >= 8'd2) r = from_sint(vb >> 48, 16);
          tvf_pkg::TC_U32: if (bc >= 8'd4) r = from_uint(vb >> 32);
          tvf_pkg::TC_S32: if (bc >= 8'd4) r = from_sint(vb >> 32, 32);
          tvf_pkg::TC_U64: if (bc >= 8'd8) r = from_uint(vb);
          tvf_pkg::TC_S64: if (bc >= 8'd8) r = from_sint(vb, 64);
          tvf_pkg::TC_F32: if (bc >= 8'd4) r = vb[63:32];
          tvf_pkg::TC_F64: if (bc >= 8'd8) r = from_double(vb);
          default: r = 32'd0;
        endcase
      end
      return r;
    endfunction

    function void note_input(logic [3:0] tc, logic [63:0] vb, logic [7:0] bc);
      pending_words = {pending_words, convert(tc, vb, bc)};
    endfunction

    function void check_output(logic [31:0] act);
      logic [31:0] exp_word;
      if (pending_words.size() == 0) begin
        $display("%0t: unexpected output beat, expected none, actual %h", $time, act);
        errors++;
        return;
      end
      exp_word = pending_words.pop_front();
      if (act !== exp_word) begin
        $display("%0t: float_bits mismatch, expected %h, actual %h", $time, exp_word, act);
        errors++;
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [3:0]  type_code = '0;
  logic [63:0] value_bytes = '0;
  logic [7:0]  byte_count = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [31:0] float_bits;

  float_scoreboard sb = new();
  bit in_taken = 1'b0;
  bit quiet_tail = 1'b0;

  typed_value_to_float32 dut (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
    .type_code(type_code), .value_bytes(value_bytes), .byte_count(byte_count),
    .out_valid(out_valid), .out_ready(out_ready), .float_bits(float_bits)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    in_taken = !rst && in_valid && in_ready;
    if (in_taken) sb.note_input(type_code, value_bytes, byte_count);
    if (!rst && out_valid && out_ready) sb.check_output(float_bits);
  end

  // Receiver stalls in random bursts until the quiet tail of the run.
  initial begin
    int n;
    @(negedge clk);
    forever begin
      if (!quiet_tail && $urandom_range(0, 3) == 0) begin
        out_ready = 1'b0;
        n = $urandom_range(1, 11);
        repeat (n) @(negedge clk);
      end else begin
        out_ready = 1'b1;
        n = $urandom_range(1, 20);
        repeat (n) @(negedge clk);
      end
    end
  end

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic send_beat(logic [3:0] tc, logic [63:0] vb, logic [7:0] bc);
    int gap;
    if (!quiet_tail && $urandom_range(0, 4) == 0) begin
      in_valid = 1'b0;
      gap = $urandom_range(1, 11);
      repeat (gap) @(negedge clk);
    end
    in_valid    = 1'b1;
    type_code   = tc;
    value_bytes = vb;
    byte_count  = bc;
    do @(negedge clk); while (!in_taken);
  endtask

  function automatic logic [63:0] rand_word();
    return {$urandom(), $urandom()};
  endfunction

  function automatic logic [63:0] rand_double();
    logic [63:0] d;
    d = rand_word();
    case ($urandom_range(0, 7))
      0: d[62:52] = 11'h7FF;
      1: d[62:52] = 11'h000;
      2: d[62:52] = 11'd1023 + 11'($urandom_range(100, 140)) - 11'd100;
      3: d[62:52] = 11'd1023 - 11'($urandom_range(120, 160));
      4: d[28:0]  = {1'b1, 28'd0};
      default: ;
    endcase
    return d;
  endfunction

  function automatic logic [7:0] full_count(logic [3:0] tc);
    case (tc)
      tvf_pkg::TC_U8, tvf_pkg::TC_S8:   return 8'd1;
      tvf_pkg::TC_U16, tvf_pkg::TC_S16: return 8'd2;
      tvf_pkg::TC_U32, tvf_pkg::TC_S32, tvf_pkg::TC_F32: return 8'd4;
      default: return 8'd8;
    endcase
  endfunction

  initial begin
    logic [3:0]  tc;
    logic [63:0] vb;
    logic [7:0]  bc;
    repeat (10) @(negedge clk);
    rst = 1'b0;

    // Directed beats.
    send_beat(tvf_pkg::TC_U8,  64'hFF00_0000_0000_0000, 8'd1);
    send_beat(tvf_pkg::TC_S8,  64'h8000_0000_0000_0000, 8'd255);
    send_beat(tvf_pkg::TC_S8,  64'h7F12_3456_789A_BCDE, 8'd1);
    send_beat(tvf_pkg::TC_U16, 64'hFFFF_0000_0000_0000, 8'd2);
    send_beat(tvf_pkg::TC_U16, 64'hFFFF_0000_0000_0000, 8'd1);
    send_beat(tvf_pkg::TC_S16, 64'h8000_FFFF_FFFF_FFFF, 8'd2);
    send_beat(tvf_pkg::TC_U32, 64'hFFFF_FFFF_0000_0000, 8'd4);
    send_beat(tvf_pkg::TC_S32, 64'h8000_0001_0000_0000, 8'd3);
    send_beat(tvf_pkg::TC_S32, 64'h8000_0000_0000_0000, 8'd4);
    send_beat(tvf_pkg::TC_U64, 64'hFFFF_FFFF_FFFF_FFFF, 8'd8);
    send_beat(tvf_pkg::TC_U64, 64'h0000_0000_0100_0001, 8'd8);
    send_beat(tvf_pkg::TC_S64, 64'h8000_0000_0000_0000, 8'd8);
    send_beat(tvf_pkg::TC_S64, 64'h0000_0000_0000_0000, 8'd8);
    send_beat(tvf_pkg::TC_F32, 64'h7F80_0001_0000_0000, 8'd4);
    send_beat(tvf_pkg::TC_F64, 64'h8000_0000_0000_0000, 8'd8);
    send_beat(tvf_pkg::TC_F64, 64'hFFF0_0000_0000_0000, 8'd8);
    send_beat(tvf_pkg::TC_F64, 64'h7FF0_0000_2000_0000, 8'd8);
    send_beat(tvf_pkg::TC_F64, 64'h47EF_FFFF_F000_0000, 8'd8);
    send_beat(tvf_pkg::TC_F64, 64'h36A0_0000_0000_0000, 8'd8);
    send_beat(tvf_pkg::TC_F64, 64'h0000_0000_0000_0001, 8'd8);
    send_beat(tvf_pkg::TC_F64, 64'h3FF0_0000_0000_0000, 8'd7);
    send_beat(TC_OTHER_LO, 64'hFFFF_FFFF_FFFF_FFFF, 8'd8);
    send_beat(TC_OTHER_HI, 64'hFFFF_FFFF_FFFF_FFFF, 8'd255);
    send_beat(tvf_pkg::TC_U8, 64'hFFFF_FFFF_FFFF_FFFF, 8'd0);

    // Hold off until the pipeline has drained once.
    in_valid = 1'b0;
    while (sb.pending_words.size() != 0) @(negedge clk);

    for (int i = 0; i < N_RANDOM; i++) begin
      if (i == N_RANDOM - 200) quiet_tail = 1'b1;
      if ($urandom_range(0, 9) == 0) tc = 4'($urandom_range(TC_OTHER_LO, TC_OTHER_HI));
      else tc = 4'($urandom_range(tvf_pkg::TC_U8, tvf_pkg::TC_F64));
      vb = (tc == tvf_pkg::TC_F64) ? rand_double() : rand_word();
      if ($urandom_range(0, 5) == 0) vb = vb >> $urandom_range(0, 63);
      case ($urandom_range(0, 9))
        0: bc = 8'($urandom_range(0, 255));
        1: bc = full_count(tc) - 8'd1;
        default: bc = full_count(tc) + 8'($urandom_range(0, 1) * $urandom_range(0, 8));
      endcase
      send_beat(tc, vb, bc);
    end
    in_valid = 1'b0;

    while (sb.pending_words.size() != 0) @(negedge clk);
    repeat (10) @(negedge clk);
    if (sb.errors == 0 && sb.pending_words.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("Regression FAIL");
    $finish;
  end

endmodule

### files.f
rtl/tvf_pkg.sv
rtl/tvf_decode.sv
rtl/typed_value_to_float32.sv
rtl/tvf_checker.sv
dv/tb_typed_value_to_float32.sv
